FILE: hw/rtl/lpt_pkg.sv
// shared types, widths, register indexes and helpers for the luma preserving tint block
package lpt_pkg;

  // pixel channel and luma widths
  localparam int unsigned PixW   = 8;
  localparam int unsigned LumaW  = 8;
  localparam int unsigned ScaleW = 17;
  localparam int unsigned TermW  = 18;
  localparam int unsigned SumW   = 20;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_TINT_RED   = 2'd0,
    REG_TINT_GREEN = 2'd1,
    REG_TINT_BLUE  = 2'd2
  } reg_index_t;

  // per-channel chroma offsets, rounding constant folded in
  typedef struct packed {
    logic signed [TermW-1:0] red_term;
    logic signed [TermW-1:0] green_term;
    logic signed [TermW-1:0] blue_term;
  } chroma_terms_t;

  // stage load enables from the pipeline control
  typedef struct packed {
    logic load1;
    logic load2;
    logic load3;
  } pipe_ctrl_t;

  // floor divide by 256 then clamp to 0..255
  function automatic logic [PixW-1:0] clamp_pixel(input logic signed [SumW-1:0] sum);
    logic signed [SumW-9:0] shifted;
    logic [PixW-1:0] result;
    shifted = sum[SumW-1:8];
    if (shifted[SumW-9]) begin
      result = '0;
    end else if (|shifted[SumW-10:PixW]) begin
      result = '1;
    end else begin
      result = shifted[PixW-1:0];
    end
    return result;
  endfunction

endpackage

FILE: hw/rtl/lpt_chroma.sv
// tint registers and the chroma terms derived from them
module lpt_chroma (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [lpt_pkg::PixW-1:0] cfg_data,
  output lpt_pkg::chroma_terms_t  terms
);

  logic [lpt_pkg::PixW-1:0] tint_red;
  logic [lpt_pkg::PixW-1:0] tint_green;
  logic [lpt_pkg::PixW-1:0] tint_blue;
  logic signed [16:0] u_sum;
  logic signed [16:0] v_sum;
  logic signed [7:0] chroma_d;
  logic signed [7:0] chroma_e;
  lpt_pkg::chroma_terms_t terms_next;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      tint_red   <= '0;
      tint_green <= '0;
      tint_blue  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        lpt_pkg::REG_TINT_RED:   tint_red   <= cfg_data;
        lpt_pkg::REG_TINT_GREEN: tint_green <= cfg_data;
        lpt_pkg::REG_TINT_BLUE:  tint_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // u and v of the tint color, rounded
  assign u_sum = 17'sd128
               + 17'sd112 * $signed({9'd0, tint_blue})
               - 17'sd38  * $signed({9'd0, tint_red})
               - 17'sd74  * $signed({9'd0, tint_green});
  assign v_sum = 17'sd128
               + 17'sd112 * $signed({9'd0, tint_red})
               - 17'sd94  * $signed({9'd0, tint_green})
               - 17'sd18  * $signed({9'd0, tint_blue});

  // floor shift, upper bits are the centered chroma
  always_ff @(posedge clk) begin
    chroma_d <= u_sum[15:8];
    chroma_e <= v_sum[15:8];
  end

  // back-conversion offsets per output channel
  always_comb begin
    terms_next.red_term   = 18'sd128 + 18'sd409 * 18'(chroma_e);
    terms_next.green_term = 18'sd128 - 18'sd100 * 18'(chroma_d) - 18'sd208 * 18'(chroma_e);
    terms_next.blue_term  = 18'sd128 + 18'sd516 * 18'(chroma_d);
  end

  always_ff @(posedge clk) begin
    terms <= terms_next;
  end

endmodule

FILE: hw/rtl/lpt_luma.sv
// first two pipeline stages: luma and its scaled form
module lpt_luma (
  input  logic                       clk,
  input  lpt_pkg::pipe_ctrl_t        ctrl,
  input  logic [lpt_pkg::PixW-1:0]   in_red,
  input  logic [lpt_pkg::PixW-1:0]   in_green,
  input  logic [lpt_pkg::PixW-1:0]   in_blue,
  output logic [lpt_pkg::ScaleW-1:0] luma_scaled
);

  logic [15:0] luma_sum;
  logic [lpt_pkg::LumaW-1:0] luma_c;

  // weighted sum with rounding, luma minus 16 is the upper byte
  assign luma_sum = 16'd128
                  + 16'd66  * 16'(in_red)
                  + 16'd129 * 16'(in_green)
                  + 16'd25  * 16'(in_blue);

  // stage one
  always_ff @(posedge clk) begin
    if (ctrl.load1) begin
      luma_c <= luma_sum[15:8];
    end
  end

  // stage two: luma gain
  always_ff @(posedge clk) begin
    if (ctrl.load2) begin
      luma_scaled <= 17'd298 * 17'(luma_c);
    end
  end

endmodule

FILE: hw/rtl/lpt_recon.sv
// last stage: add chroma terms, scale down and clamp
module lpt_recon (
  input  logic                       clk,
  input  lpt_pkg::pipe_ctrl_t        ctrl,
  input  logic [lpt_pkg::ScaleW-1:0] luma_scaled,
  input  lpt_pkg::chroma_terms_t     terms,
  output logic [lpt_pkg::PixW-1:0]   out_red,
  output logic [lpt_pkg::PixW-1:0]   out_green,
  output logic [lpt_pkg::PixW-1:0]   out_blue
);

  logic signed [lpt_pkg::SumW-1:0] luma_ext;
  logic signed [lpt_pkg::SumW-1:0] red_sum;
  logic signed [lpt_pkg::SumW-1:0] green_sum;
  logic signed [lpt_pkg::SumW-1:0] blue_sum;

  // per-channel sums
  assign luma_ext  = $signed({3'd0, luma_scaled});
  assign red_sum   = luma_ext + 20'(terms.red_term);
  assign green_sum = luma_ext + 20'(terms.green_term);
  assign blue_sum  = luma_ext + 20'(terms.blue_term);

  // output register
  always_ff @(posedge clk) begin
    if (ctrl.load3) begin
      out_red   <= lpt_pkg::clamp_pixel(red_sum);
      out_green <= lpt_pkg::clamp_pixel(green_sum);
      out_blue  <= lpt_pkg::clamp_pixel(blue_sum);
    end
  end

endmodule

FILE: hw/rtl/luma_preserving_tint.sv
// top level of the luma preserving tint pixel pipeline
//
// Recolors 8-bit RGB pixels: keeps each pixel's BT.601 luma and takes the
// chroma from the tint color held in three registers (red, green, blue at
// indexes 0, 1, 2 of the cfg port). cfg_ready is always high; write the tint
// only while no pixel is in flight.
// Input pixels arrive on in_valid/in_ready, results leave on out_valid/out_ready.
// The pipeline takes one pixel per clock while out_ready is high; its three
// register stages (luma, luma gain, chroma add and clamp) each hold one pixel
// with its own valid bit. When the receiver stalls, stages fill up behind the
// output register and in_ready drops only once every stage holds a pixel;
// nothing is lost or repeated. Reset clears all valid bits and the tint color
// to black; a tint write reaches the chroma terms through the tint register,
// the chroma_d/chroma_e register and the terms register.
module luma_preserving_tint (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [lpt_pkg::PixW-1:0] in_red,
  input  logic [lpt_pkg::PixW-1:0] in_green,
  input  logic [lpt_pkg::PixW-1:0] in_blue,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [lpt_pkg::PixW-1:0] out_red,
  output logic [lpt_pkg::PixW-1:0] out_green,
  output logic [lpt_pkg::PixW-1:0] out_blue,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [lpt_pkg::PixW-1:0] cfg_data
);

  logic valid1;
  logic valid2;
  logic valid3;
  logic ready1;
  logic ready2;
  logic ready3;
  lpt_pkg::pipe_ctrl_t ctrl;
  lpt_pkg::chroma_terms_t terms;
  logic [lpt_pkg::ScaleW-1:0] luma_scaled;

  // stage advance: a stage moves when empty or when the next one moves
  assign ready3 = !valid3 || out_ready;
  assign ready2 = !valid2 || ready3;
  assign ready1 = !valid1 || ready2;

  assign ctrl.load1 = ready1 && in_valid;
  assign ctrl.load2 = ready2 && valid1;
  assign ctrl.load3 = ready3 && valid2;

  assign in_ready  = ready1;
  assign out_valid = valid3;
  assign cfg_ready = 1'b1;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      if (ready1) valid1 <= in_valid;
      if (ready2) valid2 <= valid1;
      if (ready3) valid3 <= valid2;
    end
  end

  lpt_chroma u_chroma (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .terms     (terms)
  );

  lpt_luma u_luma (
    .clk         (clk),
    .ctrl        (ctrl),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .luma_scaled (luma_scaled)
  );

  lpt_recon u_recon (
    .clk         (clk),
    .ctrl        (ctrl),
    .luma_scaled (luma_scaled),
    .terms       (terms),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

endmodule
